FILE: hw/rtl/lzc_pkg.sv
package lzc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 3;

  localparam int PIX_W     = 8;
  localparam int WT_W      = 16;
  localparam int DIM_W     = 11;
  localparam int CFG_RAD_W = 2;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 5;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int FRM_RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int TAP_N     = 2 * MAX_RADIUS + 1;
  localparam int TAP_W     = $clog2(TAP_N);
  localparam int RING_BITS = $clog2(2 * MAX_RADIUS + 6);
  localparam int ADDR_W    = RING_BITS + COL_W;
  localparam int POS_W     = ((COL_W > ROW_W) ? COL_W : ROW_W) + 3;
  localparam int LAG_W     = $clog2((MAX_RADIUS + 2) * MAX_WIDTH + MAX_RADIUS + 1);

  localparam int PROD_W    = WT_W + PIX_W;
  localparam int T_W       = PROD_W + TAP_W;
  localparam int MT_W      = WT_W + T_W;
  localparam int ACC_W     = MT_W + TAP_W;
  localparam int FRAC_SHIFT = 2 * WT_W;

  localparam int SM_N      = 13;
  localparam int SM_IDX_W  = $clog2(SM_N);
  localparam int LAP_W     = 11;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [MAX_RADIUS:0][WT_W-1:0] wts_t;
  typedef logic [SM_N-1:0][PIX_W-1:0] smooth_set_t;

  typedef struct packed {
    logic [ROW_W-1:0]     y;
    logic [COL_W-1:0]     x;
    logic [ROW_W:0]       h;
    logic [COL_W:0]       w;
    logic [FRM_RAD_W-1:0] r;
    wts_t                 wt;
  } lzc_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LOAD
  } ctl_state_t;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_KERNEL_RADIUS  = 3'd2,
    REG_GAUSS_WEIGHT_0 = 3'd3,
    REG_GAUSS_WEIGHT_1 = 3'd4,
    REG_GAUSS_WEIGHT_2 = 3'd5,
    REG_GAUSS_WEIGHT_3 = 3'd6
  } cfg_reg_t;

  // Diamond of smoothed samples around the result pixel, radius two.
  function automatic logic signed [2:0] sm_dy(logic [SM_IDX_W-1:0] idx);
    unique case (idx)
      4'd0:                         sm_dy = -3'sd2;
      4'd1, 4'd2, 4'd3:             sm_dy = -3'sd1;
      4'd9, 4'd10, 4'd11:           sm_dy = 3'sd1;
      4'd12:                        sm_dy = 3'sd2;
      default:                      sm_dy = 3'sd0;
    endcase
  endfunction

  function automatic logic signed [2:0] sm_dx(logic [SM_IDX_W-1:0] idx);
    unique case (idx)
      4'd4:                         sm_dx = -3'sd2;
      4'd1, 4'd5, 4'd9:             sm_dx = -3'sd1;
      4'd3, 4'd7, 4'd11:            sm_dx = 3'sd1;
      4'd8:                         sm_dx = 3'sd2;
      default:                      sm_dx = 3'sd0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/lzc_if.sv
interface lzc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [lzc_pkg::PIX_W-1:0] pixel;

  modport source (output valid, command, pixel, input ready);
  modport sink   (input valid, command, pixel, output ready);
endinterface

interface lzc_out_if;
  logic                      valid;
  logic                      ready;
  logic [lzc_pkg::PIX_W-1:0] edge_value;
  logic                      frame_end;

  modport source (output valid, edge_value, frame_end, input ready);
  modport sink   (input valid, edge_value, frame_end, output ready);
endinterface

FILE: hw/rtl/lzc_raw_store.sv
module lzc_raw_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [lzc_pkg::ADDR_W-1:0] waddr,
  input  logic [lzc_pkg::PIX_W-1:0]  wdata,
  input  logic [lzc_pkg::ADDR_W-1:0] raddr,
  output logic [lzc_pkg::PIX_W-1:0]  rdata
);

  logic [lzc_pkg::PIX_W-1:0] mem [2**lzc_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/lzc_gauss.sv
module lzc_gauss (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  lzc_pkg::lzc_job_t          job,
  output logic [lzc_pkg::ADDR_W-1:0] rd_addr,
  input  logic [lzc_pkg::PIX_W-1:0]  rd_data,
  output lzc_pkg::smooth_set_t       smooth,
  output logic                       done
);

  function automatic lzc_pkg::pos_t clamp_pos(lzc_pkg::pos_t v, lzc_pkg::pos_t n);
    if (v < 0) begin
      clamp_pos = '0;
    end else if (v >= n) begin
      clamp_pos = n - 1;
    end else begin
      clamp_pos = v;
    end
  endfunction

  function automatic logic [lzc_pkg::FRM_RAD_W-1:0] tap_dist(
    logic [lzc_pkg::TAP_W-1:0] k, logic [lzc_pkg::FRM_RAD_W-1:0] r);
    logic [lzc_pkg::TAP_W-1:0] rr;
    rr = lzc_pkg::TAP_W'(r);
    if (k >= rr) begin
      tap_dist = lzc_pkg::FRM_RAD_W'(k - rr);
    end else begin
      tap_dist = lzc_pkg::FRM_RAD_W'(rr - k);
    end
  endfunction

  logic                             busy;
  logic [lzc_pkg::SM_IDX_W-1:0]     sidx;
  logic [lzc_pkg::SM_IDX_W-1:0]     oidx;
  logic [lzc_pkg::TAP_W-1:0]        mi;
  logic [lzc_pkg::TAP_W-1:0]        ni;
  logic [lzc_pkg::TAP_W-1:0]        two_r;
  logic                             row_last;
  logic                             sm_last;
  lzc_pkg::pos_t                    sy;
  lzc_pkg::pos_t                    sx;
  lzc_pkg::pos_t                    ry;
  lzc_pkg::pos_t                    rx;
  logic [lzc_pkg::WT_W-1:0]         wn;
  logic [lzc_pkg::WT_W-1:0]         wm;

  logic                             s1_valid;
  logic                             s1_rowlast;
  logic                             s1_smlast;
  logic [lzc_pkg::WT_W-1:0]         s1_wn;
  logic [lzc_pkg::WT_W-1:0]         s1_wm;
  logic                             s2_valid;
  logic                             s2_rowlast;
  logic                             s2_smlast;
  logic [lzc_pkg::WT_W-1:0]         s2_wm;
  logic [lzc_pkg::PROD_W-1:0]       s2_prod;
  logic [lzc_pkg::T_W-1:0]          t;
  logic [lzc_pkg::T_W-1:0]          tsum;
  logic                             s3_valid;
  logic                             s3_smlast;
  logic [lzc_pkg::WT_W-1:0]         s3_wm;
  logic [lzc_pkg::T_W-1:0]          s3_rowtot;
  logic                             s4_valid;
  logic                             s4_smlast;
  logic [lzc_pkg::MT_W-1:0]         s4_prod;
  logic [lzc_pkg::ACC_W-1:0]        acc;
  logic [lzc_pkg::ACC_W-1:0]        asum;
  logic [lzc_pkg::ACC_W-lzc_pkg::FRAC_SHIFT-1:0] hi;
  logic [lzc_pkg::PIX_W-1:0]        sat;

  // Tap address: clamp the smoothed sample position, then the raw tap.
  always_comb begin
    two_r    = lzc_pkg::TAP_W'(job.r) << 1;
    row_last = (ni == two_r);
    sm_last  = row_last && (mi == two_r);
    sy = clamp_pos(lzc_pkg::pos_t'(job.y) + lzc_pkg::pos_t'(lzc_pkg::sm_dy(sidx)),
                   lzc_pkg::pos_t'(job.h));
    sx = clamp_pos(lzc_pkg::pos_t'(job.x) + lzc_pkg::pos_t'(lzc_pkg::sm_dx(sidx)),
                   lzc_pkg::pos_t'(job.w));
    ry = clamp_pos(sy + lzc_pkg::pos_t'(mi) - lzc_pkg::pos_t'(job.r),
                   lzc_pkg::pos_t'(job.h));
    rx = clamp_pos(sx + lzc_pkg::pos_t'(ni) - lzc_pkg::pos_t'(job.r),
                   lzc_pkg::pos_t'(job.w));
    rd_addr = {ry[lzc_pkg::RING_BITS-1:0], rx[lzc_pkg::COL_W-1:0]};
    wn = job.wt[tap_dist(ni, job.r)];
    wm = job.wt[tap_dist(mi, job.r)];
  end

  always_comb begin
    tsum = t + lzc_pkg::T_W'(s2_prod);
    asum = acc + lzc_pkg::ACC_W'(s4_prod);
    hi   = asum[lzc_pkg::ACC_W-1:lzc_pkg::FRAC_SHIFT];
    if (hi > $bits(hi)'(255)) begin
      sat = 8'd255;
    end else begin
      sat = hi[lzc_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sidx     <= '0;
      mi       <= '0;
      ni       <= '0;
      oidx     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sidx <= '0;
        mi   <= '0;
        ni   <= '0;
        oidx <= '0;
      end else if (busy) begin
        if (sm_last) begin
          ni <= '0;
          mi <= '0;
          sidx <= sidx + 1'b1;
          if (sidx == lzc_pkg::SM_IDX_W'(lzc_pkg::SM_N - 1)) begin
            busy <= 1'b0;
          end
        end else if (row_last) begin
          ni <= '0;
          mi <= mi + 1'b1;
        end else begin
          ni <= ni + 1'b1;
        end
      end
      s1_valid <= busy && !start;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_rowlast;
      s4_valid <= s3_valid;
      if (s4_valid && s4_smlast) begin
        oidx <= oidx + 1'b1;
        if (oidx == lzc_pkg::SM_IDX_W'(lzc_pkg::SM_N - 1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_rowlast <= row_last;
    s1_smlast  <= sm_last;
    s1_wn      <= wn;
    s1_wm      <= wm;
    s2_rowlast <= s1_rowlast;
    s2_smlast  <= s1_smlast;
    s2_wm      <= s1_wm;
    s2_prod    <= lzc_pkg::PROD_W'(s1_wn) * lzc_pkg::PROD_W'(rd_data);
    s3_smlast  <= s2_smlast;
    s3_wm      <= s2_wm;
    s3_rowtot  <= tsum;
    s4_smlast  <= s3_smlast;
    s4_prod    <= lzc_pkg::MT_W'(s3_wm) * lzc_pkg::MT_W'(s3_rowtot);
    if (start) begin
      t   <= '0;
      acc <= '0;
    end else begin
      if (s2_valid) begin
        t <= s2_rowlast ? '0 : tsum;
      end
      if (s4_valid) begin
        acc <= s4_smlast ? '0 : asum;
      end
    end
    if (s4_valid && s4_smlast) begin
      smooth[oidx] <= sat;
    end
  end

endmodule

FILE: hw/rtl/lzc_zero_cross.sv
module lzc_zero_cross (
  input  lzc_pkg::smooth_set_t      smooth,
  output logic [lzc_pkg::PIX_W-1:0] edge_value
);

  typedef logic signed [lzc_pkg::LAP_W-1:0] lap_t;

  function automatic lap_t lap5(logic [lzc_pkg::PIX_W-1:0] c, logic [lzc_pkg::PIX_W-1:0] u,
                                logic [lzc_pkg::PIX_W-1:0] d, logic [lzc_pkg::PIX_W-1:0] l,
                                logic [lzc_pkg::PIX_W-1:0] r);
    lap5 = (lap_t'(c) <<< 2) - lap_t'(u) - lap_t'(d) - lap_t'(l) - lap_t'(r);
  endfunction

  function automatic logic opposite(lap_t a, lap_t b);
    opposite = (a > 0 && b < 0) || (a < 0 && b > 0);
  endfunction

  lap_t lc;
  lap_t lu;
  lap_t ld;
  lap_t ll;
  lap_t lr;

  // Sample order: row -2 (0), row -1 (1..3), row 0 (4..8), row +1 (9..11), row +2 (12).
  always_comb begin
    lc = lap5(smooth[6],  smooth[2], smooth[10], smooth[5], smooth[7]);
    lu = lap5(smooth[2],  smooth[0], smooth[6],  smooth[1], smooth[3]);
    ld = lap5(smooth[10], smooth[6], smooth[12], smooth[9], smooth[11]);
    ll = lap5(smooth[5],  smooth[1], smooth[9],  smooth[4], smooth[6]);
    lr = lap5(smooth[7],  smooth[3], smooth[11], smooth[6], smooth[8]);
    if (opposite(lc, lu) || opposite(lc, ld) || opposite(lc, ll) || opposite(lc, lr)) begin
      edge_value = lzc_pkg::EDGE_ON;
    end else begin
      edge_value = lzc_pkg::EDGE_OFF;
    end
  end

endmodule

FILE: hw/rtl/log_zero_crossing_edge_detector_top.sv
// Laplacian-of-Gaussian edge detector. Pixels enter in raster order; each result word is
// 255 on a zero crossing of the Laplacian of the smoothed image, 0 otherwise, and the
// one-pixel border is always 0. The result for raster position p comes out after pixel
// p + (R+2)*W + R is taken; once the frame is in, each drain word (or extra pixel word)
// pulls the next pending result. Geometry, radius and weights are latched at the first
// pixel of a frame. Words are taken one at a time: the input is not ready again until
// the result that a word yields, if any, is loaded into the output register; an interior
// result first has all 13 smoothed samples around it recomputed one tap per cycle through
// the single read port of the raw line memory. A result word that the sink does not take
// holds the next result, and with it the input, for as long as it waits.
module log_zero_crossing_edge_detector_top (
  input  logic                          clk,
  input  logic                          rst,
  lzc_in_if.sink                        pixels,
  lzc_out_if.source                     edges,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lzc_pkg::PADDR_W-1:0]   paddr,
  input  logic [lzc_pkg::DATA_W-1:0]    pwdata,
  output logic [lzc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  lzc_pkg::ctl_state_t                  state;
  lzc_pkg::ctl_state_t                  state_next;

  logic [lzc_pkg::DIM_W-1:0]            cfg_width;
  logic [lzc_pkg::DIM_W-1:0]            cfg_height;
  logic [lzc_pkg::CFG_RAD_W-1:0]        cfg_radius;
  logic [3:0][lzc_pkg::WT_W-1:0]        cfg_wt;
  lzc_pkg::cfg_reg_t                    reg_sel;
  logic                                 cfg_write;

  logic                                 active;
  logic [lzc_pkg::COL_W:0]              frm_w;
  logic [lzc_pkg::ROW_W:0]              frm_h;
  logic [lzc_pkg::FRM_RAD_W-1:0]        frm_r;
  lzc_pkg::wts_t                        frm_wt;
  logic [lzc_pkg::LAG_W-1:0]            frm_lag;
  logic [lzc_pkg::ROW_W:0]              in_row;
  logic [lzc_pkg::COL_W-1:0]            in_col;
  logic [lzc_pkg::ROW_W:0]              out_row;
  logic [lzc_pkg::COL_W-1:0]            out_col;
  logic [lzc_pkg::LAG_W-1:0]            pend;

  logic [lzc_pkg::COL_W:0]              sat_w;
  logic [lzc_pkg::ROW_W:0]              sat_h;
  logic [lzc_pkg::FRM_RAD_W-1:0]        sat_r;
  lzc_pkg::wts_t                        sat_wt;
  logic [lzc_pkg::LAG_W-1:0]            sat_lag;

  logic [lzc_pkg::COL_W:0]              eff_w;
  logic [lzc_pkg::ROW_W:0]              eff_h;
  logic [lzc_pkg::LAG_W-1:0]            eff_lag;
  logic [lzc_pkg::ROW_W:0]              cur_in_row;
  logic [lzc_pkg::COL_W-1:0]            cur_in_col;
  logic [lzc_pkg::ROW_W:0]              cur_out_row;
  logic [lzc_pkg::COL_W-1:0]            cur_out_col;
  logic [lzc_pkg::LAG_W-1:0]            cur_pend;
  logic [lzc_pkg::COL_W:0]              in_col_inc;
  logic [lzc_pkg::COL_W:0]              out_col_inc;
  logic [lzc_pkg::ROW_W:0]              out_row_adv;

  logic                                 accept;
  logic                                 drain_mode;
  logic                                 take_pixel;
  logic                                 emit;
  logic                                 interior;
  logic                                 last_pos;

  logic [lzc_pkg::ROW_W-1:0]            e_y;
  logic [lzc_pkg::COL_W-1:0]            e_x;
  logic                                 e_interior;
  logic                                 e_frame_end;
  logic                                 g_start;
  logic                                 g_done;
  lzc_pkg::lzc_job_t                    job;
  lzc_pkg::smooth_set_t                 smooth;
  logic [lzc_pkg::ADDR_W-1:0]           rd_addr;
  logic [lzc_pkg::PIX_W-1:0]            rd_data;
  logic [lzc_pkg::PIX_W-1:0]            edge_calc;
  logic                                 load_out;

  logic                                 out_valid;
  logic [lzc_pkg::PIX_W-1:0]            out_edge;
  logic                                 out_fe;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_sel   = lzc_pkg::cfg_reg_t'(paddr[lzc_pkg::PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      lzc_pkg::REG_IMAGE_WIDTH:    prdata = lzc_pkg::DATA_W'(cfg_width);
      lzc_pkg::REG_IMAGE_HEIGHT:   prdata = lzc_pkg::DATA_W'(cfg_height);
      lzc_pkg::REG_KERNEL_RADIUS:  prdata = lzc_pkg::DATA_W'(cfg_radius);
      lzc_pkg::REG_GAUSS_WEIGHT_0: prdata = lzc_pkg::DATA_W'(cfg_wt[0]);
      lzc_pkg::REG_GAUSS_WEIGHT_1: prdata = lzc_pkg::DATA_W'(cfg_wt[1]);
      lzc_pkg::REG_GAUSS_WEIGHT_2: prdata = lzc_pkg::DATA_W'(cfg_wt[2]);
      lzc_pkg::REG_GAUSS_WEIGHT_3: prdata = lzc_pkg::DATA_W'(cfg_wt[3]);
      default:                     prdata = '0;
    endcase
  end

  // Frame geometry as it would be latched by the next pixel.
  always_comb begin
    if (cfg_width == '0) begin
      sat_w = (lzc_pkg::COL_W + 1)'(1);
    end else if (32'(cfg_width) > 32'(lzc_pkg::MAX_WIDTH)) begin
      sat_w = (lzc_pkg::COL_W + 1)'(lzc_pkg::MAX_WIDTH);
    end else begin
      sat_w = (lzc_pkg::COL_W + 1)'(cfg_width);
    end
    if (cfg_height == '0) begin
      sat_h = (lzc_pkg::ROW_W + 1)'(1);
    end else if (32'(cfg_height) > 32'(lzc_pkg::MAX_HEIGHT)) begin
      sat_h = (lzc_pkg::ROW_W + 1)'(lzc_pkg::MAX_HEIGHT);
    end else begin
      sat_h = (lzc_pkg::ROW_W + 1)'(cfg_height);
    end
    if (cfg_radius == '0) begin
      sat_r = lzc_pkg::FRM_RAD_W'(1);
    end else if (32'(cfg_radius) > 32'(lzc_pkg::MAX_RADIUS)) begin
      sat_r = lzc_pkg::FRM_RAD_W'(lzc_pkg::MAX_RADIUS);
    end else begin
      sat_r = lzc_pkg::FRM_RAD_W'(cfg_radius);
    end
    for (int i = 0; i <= lzc_pkg::MAX_RADIUS; i++) begin
      sat_wt[i] = cfg_wt[i];
    end
    sat_lag = (lzc_pkg::LAG_W'(sat_r) + lzc_pkg::LAG_W'(2)) * lzc_pkg::LAG_W'(sat_w)
            + lzc_pkg::LAG_W'(sat_r);
  end

  // Word decode.
  always_comb begin
    accept      = pixels.valid && pixels.ready;
    drain_mode  = active && (in_row >= frm_h);
    take_pixel  = accept && !pixels.command && !drain_mode;
    eff_w       = active ? frm_w : sat_w;
    eff_h       = active ? frm_h : sat_h;
    eff_lag     = active ? frm_lag : sat_lag;
    cur_in_row  = active ? in_row : '0;
    cur_in_col  = active ? in_col : '0;
    cur_out_row = active ? out_row : '0;
    cur_out_col = active ? out_col : '0;
    cur_pend    = active ? pend : '0;
    emit        = accept && (drain_mode || (take_pixel && cur_pend >= eff_lag));
    in_col_inc  = (lzc_pkg::COL_W + 1)'(cur_in_col) + 1'b1;
    out_col_inc = (lzc_pkg::COL_W + 1)'(cur_out_col) + 1'b1;
    out_row_adv = (out_col_inc == eff_w) ? cur_out_row + 1'b1 : cur_out_row;
    interior    = (cur_out_row != '0) && (cur_out_col != '0)
               && (cur_out_row != eff_h - 1'b1)
               && ((lzc_pkg::COL_W + 1)'(cur_out_col) != eff_w - 1'b1);
    last_pos    = (cur_out_row == eff_h - 1'b1)
               && ((lzc_pkg::COL_W + 1)'(cur_out_col) == eff_w - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= lzc_pkg::DIM_W'(1024);
      cfg_height <= lzc_pkg::DIM_W'(1024);
      cfg_radius <= lzc_pkg::CFG_RAD_W'(3);
      cfg_wt[0]  <= 16'd26154;
      cfg_wt[1]  <= 16'd15862;
      cfg_wt[2]  <= 16'd3539;
      cfg_wt[3]  <= 16'd290;
      active     <= 1'b0;
      frm_w      <= (lzc_pkg::COL_W + 1)'(1);
      frm_h      <= (lzc_pkg::ROW_W + 1)'(1);
      frm_r      <= lzc_pkg::FRM_RAD_W'(1);
      frm_wt     <= '0;
      frm_lag    <= '0;
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      pend       <= '0;
      g_start    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_sel)
          lzc_pkg::REG_IMAGE_WIDTH:    cfg_width  <= pwdata[lzc_pkg::DIM_W-1:0];
          lzc_pkg::REG_IMAGE_HEIGHT:   cfg_height <= pwdata[lzc_pkg::DIM_W-1:0];
          lzc_pkg::REG_KERNEL_RADIUS:  cfg_radius <= pwdata[lzc_pkg::CFG_RAD_W-1:0];
          lzc_pkg::REG_GAUSS_WEIGHT_0: cfg_wt[0]  <= pwdata[lzc_pkg::WT_W-1:0];
          lzc_pkg::REG_GAUSS_WEIGHT_1: cfg_wt[1]  <= pwdata[lzc_pkg::WT_W-1:0];
          lzc_pkg::REG_GAUSS_WEIGHT_2: cfg_wt[2]  <= pwdata[lzc_pkg::WT_W-1:0];
          lzc_pkg::REG_GAUSS_WEIGHT_3: cfg_wt[3]  <= pwdata[lzc_pkg::WT_W-1:0];
          default: ;
        endcase
      end
      g_start <= emit && interior;
      if (take_pixel) begin
        if (!active) begin
          frm_w   <= sat_w;
          frm_h   <= sat_h;
          frm_r   <= sat_r;
          frm_wt  <= sat_wt;
          frm_lag <= sat_lag;
        end
        if (in_col_inc == eff_w) begin
          in_col <= '0;
          in_row <= cur_in_row + 1'b1;
        end else begin
          in_col <= in_col_inc[lzc_pkg::COL_W-1:0];
          in_row <= cur_in_row;
        end
        pend <= emit ? cur_pend : cur_pend + 1'b1;
      end
      // Advance the output position; a new frame starts it at the origin.
      if (emit) begin
        out_col <= (out_col_inc == eff_w) ? '0 : out_col_inc[lzc_pkg::COL_W-1:0];
        out_row <= out_row_adv;
      end else if (take_pixel && !active) begin
        out_row <= '0;
        out_col <= '0;
      end
      if (emit && (out_row_adv >= eff_h)) begin
        active <= 1'b0;
      end else if (take_pixel) begin
        active <= 1'b1;
      end
    end
  end

  // Latch the position and flags of the result being worked on.
  always_ff @(posedge clk) begin
    if (emit) begin
      e_y         <= cur_out_row[lzc_pkg::ROW_W-1:0];
      e_x         <= cur_out_col;
      e_interior  <= interior;
      e_frame_end <= last_pos;
    end
  end

  always_comb begin
    job.y  = e_y;
    job.x  = e_x;
    job.h  = frm_h;
    job.w  = frm_w;
    job.r  = frm_r;
    job.wt = frm_wt;
  end

  lzc_raw_store u_raw_store (
    .clk   (clk),
    .we    (take_pixel),
    .waddr ({cur_in_row[lzc_pkg::RING_BITS-1:0], cur_in_col}),
    .wdata (pixels.pixel),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lzc_gauss u_gauss (
    .clk     (clk),
    .rst     (rst),
    .start   (g_start),
    .job     (job),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .smooth  (smooth),
    .done    (g_done)
  );

  lzc_zero_cross u_zero_cross (
    .smooth     (smooth),
    .edge_value (edge_calc)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lzc_pkg::ST_IDLE: begin
        if (emit) begin
          state_next = interior ? lzc_pkg::ST_RUN : lzc_pkg::ST_LOAD;
        end
      end
      lzc_pkg::ST_RUN: begin
        if (g_done) begin
          state_next = lzc_pkg::ST_LOAD;
        end
      end
      lzc_pkg::ST_LOAD: begin
        if (!out_valid || edges.ready) begin
          state_next = lzc_pkg::ST_IDLE;
        end
      end
      default: state_next = lzc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pixels.ready = (state == lzc_pkg::ST_IDLE);
    load_out     = (state == lzc_pkg::ST_LOAD) && (!out_valid || edges.ready);
  end

  // Output register: hold the word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (edges.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_edge <= e_interior ? edge_calc : lzc_pkg::EDGE_OFF;
      out_fe   <= e_frame_end;
    end
  end

  assign edges.valid      = out_valid;
  assign edges.edge_value = out_edge;
  assign edges.frame_end  = out_fe;

endmodule

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_ROWS = 3 * lzc_pkg::MAX_RADIUS + 6;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [lzc_pkg::PIX_W-1:0] edge_value;
    logic                      frame_end;
  } edge_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lzc_pkg::PADDR_W-1:0] paddr = '0;
  logic [lzc_pkg::DATA_W-1:0] pwdata = '0;
  logic [lzc_pkg::DATA_W-1:0] prdata;
  logic pready;

  lzc_in_if  in_ch ();
  lzc_out_if out_ch ();

  int errors = 0;
  int words_sent = 0;
  int src_idle = 34;
  int snk_idle = 51;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  log_zero_crossing_edge_detector_top u_top (
    .clk     (clk),
    .rst     (rst),
    .pixels  (in_ch),
    .edges   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  class edge_scoreboard;
    bit [lzc_pkg::DIM_W-1:0]     reg_w, reg_h;
    bit [lzc_pkg::CFG_RAD_W-1:0] reg_r;
    bit [lzc_pkg::WT_W-1:0]      reg_wt[4];
    int                          fw, fh, fr;
    bit [lzc_pkg::WT_W-1:0]      fwt[4];
    int                          in_row, in_col, out_row, out_col;
    bit                          active;
    byte unsigned                ring[RING_ROWS * lzc_pkg::MAX_WIDTH];
    edge_word_t                  pending[$];

    function new();
      reg_w = 11'd1024;
      reg_h = 11'd1024;
      reg_r = 2'd3;
      reg_wt[0] = 16'd26154;
      reg_wt[1] = 16'd15862;
      reg_wt[2] = 16'd3539;
      reg_wt[3] = 16'd290;
      fw = 1;
      fh = 1;
      fr = 1;
      foreach (fwt[k]) fwt[k] = '0;
      foreach (ring[k]) ring[k] = 0;
      active = 1'b0;
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function void write_reg(lzc_pkg::cfg_reg_t idx, bit [lzc_pkg::DATA_W-1:0] val);
      case (idx)
        lzc_pkg::REG_IMAGE_WIDTH:    reg_w = val[lzc_pkg::DIM_W-1:0];
        lzc_pkg::REG_IMAGE_HEIGHT:   reg_h = val[lzc_pkg::DIM_W-1:0];
        lzc_pkg::REG_KERNEL_RADIUS:  reg_r = val[lzc_pkg::CFG_RAD_W-1:0];
        lzc_pkg::REG_GAUSS_WEIGHT_0: reg_wt[0] = val[lzc_pkg::WT_W-1:0];
        lzc_pkg::REG_GAUSS_WEIGHT_1: reg_wt[1] = val[lzc_pkg::WT_W-1:0];
        lzc_pkg::REG_GAUSS_WEIGHT_2: reg_wt[2] = val[lzc_pkg::WT_W-1:0];
        lzc_pkg::REG_GAUSS_WEIGHT_3: reg_wt[3] = val[lzc_pkg::WT_W-1:0];
        default: ;
      endcase
    endfunction

    function int clampi(int v, int n);
      if (v < 0) return 0;
      if (v >= n) return n - 1;
      return v;
    endfunction

    function int raw_at(int y, int x);
      return ring[(clampi(y, fh) % RING_ROWS) * lzc_pkg::MAX_WIDTH + clampi(x, fw)];
    endfunction

    function int smooth_at(int y, int x);
      longint unsigned acc, t;
      int yy, xx;
      acc = 0;
      yy = clampi(y, fh);
      xx = clampi(x, fw);
      for (int m = -fr; m <= fr; m++) begin
        t = 0;
        for (int n = -fr; n <= fr; n++)
          t += longint'(fwt[n < 0 ? -n : n]) * raw_at(yy + m, xx + n);
        acc += longint'(fwt[m < 0 ? -m : m]) * t;
      end
      acc = acc >> 32;
      return (acc > 255) ? 255 : int'(acc);
    endfunction

    function int lap_at(int y, int x);
      return 4 * smooth_at(y, x) - smooth_at(y - 1, x) - smooth_at(y + 1, x)
           - smooth_at(y, x - 1) - smooth_at(y, x + 1);
    endfunction

    function bit opposite(int a, int b);
      return (a > 0 && b < 0) || (a < 0 && b > 0);
    endfunction

    function void push_result();
      edge_word_t w;
      int c;
      w.edge_value = lzc_pkg::EDGE_OFF;
      if (out_row != 0 && out_col != 0 && out_row != fh - 1 && out_col != fw - 1) begin
        c = lap_at(out_row, out_col);
        if (opposite(c, lap_at(out_row - 1, out_col)) ||
            opposite(c, lap_at(out_row + 1, out_col)) ||
            opposite(c, lap_at(out_row, out_col - 1)) ||
            opposite(c, lap_at(out_row, out_col + 1)))
          w.edge_value = lzc_pkg::EDGE_ON;
      end
      w.frame_end = (out_row == fh - 1 && out_col == fw - 1);
      pending.push_back(w);
      if (++out_col >= fw) begin
        out_col = 0;
        out_row++;
      end
      if (out_row >= fh) active = 1'b0;
    endfunction

    function void note_input(bit cmd, bit [lzc_pkg::PIX_W-1:0] pix);
      int pos, lag;
      // frame fully in: any word pulls the next result
      if (active && in_row >= fh) begin
        push_result();
        return;
      end
      if (cmd) return;
      if (!active) begin
        fw = (reg_w < 1) ? 1 : (reg_w > lzc_pkg::MAX_WIDTH ? lzc_pkg::MAX_WIDTH : int'(reg_w));
        fh = (reg_h < 1) ? 1
           : (reg_h > lzc_pkg::MAX_HEIGHT ? lzc_pkg::MAX_HEIGHT : int'(reg_h));
        fr = (reg_r < 1) ? 1 : int'(reg_r);
        fwt = reg_wt;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        active = 1'b1;
      end
      ring[(in_row % RING_ROWS) * lzc_pkg::MAX_WIDTH + in_col] = pix;
      pos = in_row * fw + in_col;
      if (++in_col >= fw) begin
        in_col = 0;
        in_row++;
      end
      lag = (fr + 2) * fw + fr;
      if (pos >= out_row * fw + out_col + lag) push_result();
    endfunction

    task check_result(logic [lzc_pkg::PIX_W-1:0] edge_value, logic frame_end);
      edge_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("result word with none pending: edge %0d end %0d",
                         edge_value, frame_end));
        return;
      end
      w = pending.pop_front();
      if (edge_value !== w.edge_value)
        report($sformatf("edge_value %0d, want %0d", edge_value, w.edge_value));
      if (frame_end !== w.frame_end)
        report($sformatf("frame_end %0d, want %0d", frame_end, w.frame_end));
    endtask
  endclass

  edge_scoreboard sb = new();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.pixel = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.edge_value,
                                                              out_ch.frame_end);
  end

  // watchdog: reset on any accepted word or register write
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** log_zero_crossing_edge_detector_top: FAILED **");
      $finish;
    end
  end

  task automatic send_word(bit cmd, bit [lzc_pkg::PIX_W-1:0] pix);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      in_ch.command <= 1'($urandom);
      in_ch.pixel <= 8'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.pixel <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, pix);
    words_sent++;
  endtask

  task automatic write_reg(lzc_pkg::cfg_reg_t idx, bit [lzc_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= lzc_pkg::PADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int w, int h, int r, bit [lzc_pkg::WT_W-1:0] wt[4]);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0 || sb.active) @(posedge clk);
    // let the last no-result word retire
    repeat (20) @(posedge clk);
    write_reg(lzc_pkg::REG_IMAGE_WIDTH, w);
    write_reg(lzc_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(lzc_pkg::REG_KERNEL_RADIUS, r);
    write_reg(lzc_pkg::REG_GAUSS_WEIGHT_0, wt[0]);
    write_reg(lzc_pkg::REG_GAUSS_WEIGHT_1, wt[1]);
    write_reg(lzc_pkg::REG_GAUSS_WEIGHT_2, wt[2]);
    write_reg(lzc_pkg::REG_GAUSS_WEIGHT_3, wt[3]);
  endtask

  function automatic bit [lzc_pkg::PIX_W-1:0] pattern_pixel(int style, int i, int w,
                                                            int base);
    case (style)
      0: return 8'($urandom);
      1: return 8'(base);
      2: return $urandom_range(1) ? lzc_pkg::EDGE_ON : lzc_pkg::EDGE_OFF;
      default: return 8'((i % w) * 37 + (i / w) * 11 + base);
    endcase
  endfunction

  // Send one frame, with stray drains mid-frame when noise is set, then pull out what is left.
  task automatic run_frame(int w, int h, int r, bit [lzc_pkg::WT_W-1:0] wt[4], int style,
                           bit noise);
    int fw, fh, base;
    configure(w, h, r, wt);
    fw = (w < 1) ? 1 : (w > lzc_pkg::MAX_WIDTH ? lzc_pkg::MAX_WIDTH : w);
    fh = (h < 1) ? 1 : (h > lzc_pkg::MAX_HEIGHT ? lzc_pkg::MAX_HEIGHT : h);
    base = $urandom_range(255);
    for (int i = 0; i < fw * fh; i++) begin
      if (noise && i > 0 && $urandom_range(19) == 0) send_word(1'b1, 8'($urandom));
      send_word(1'b0, pattern_pixel(style, i, fw, base));
    end
    while (sb.active) send_word($urandom_range(9) < 7, 8'($urandom));
    if (noise && $urandom_range(3) == 0) send_word(1'b1, 8'($urandom));
  endtask

  function automatic bit [lzc_pkg::WT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return 16'($urandom_range(40000, 15000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frames(int target);
    bit [lzc_pkg::WT_W-1:0] wt[4];
    int r;
    while (words_sent < target) begin
      foreach (wt[k]) wt[k] = pick_weight();
      r = $urandom_range(9);
      r = (r < 6) ? 1 : (r < 9 ? 2 : 3);
      if ($urandom_range(19) == 0) r = 0;
      run_frame($urandom_range(8, 3), $urandom_range(8, 3), r, wt, $urandom_range(3), 1'b1);
    end
  endtask

  initial begin
    bit [lzc_pkg::WT_W-1:0] wt[4];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // drain while idle, then degenerate and tiny frames
    send_word(1'b1, 8'hff);
    wt = '{16'd0, 16'd0, 16'd0, 16'd0};
    run_frame(0, 0, 0, wt, 0, 1'b0);
    wt = '{16'd26154, 16'd15862, 16'd3539, 16'd290};
    configure(3, 3, 1, wt);
    for (int i = 0; i < 9; i++)
      send_word(1'b0, (i == 4) ? lzc_pkg::EDGE_ON : lzc_pkg::EDGE_OFF);
    while (sb.active) send_word(1'b1, '0);
    wt = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
    run_frame(4, 3, 3, wt, 2, 1'b0);

    random_frames(300);
    wt = '{16'd40000, 16'd10000, 16'd2000, 16'd0};
    run_frame(40, 1, 2, wt, 0, 1'b0);
    run_frame(1, 40, 3, wt, 0, 1'b0);
    random_frames(500);

    src_idle = 51;
    snk_idle = 34;
    random_frames(750);

    src_idle = 0;
    snk_idle = 0;
    wt = '{16'd30000, 16'd17000, 16'd500, 16'd7};
    run_frame(30, 3, 1, wt, 0, 1'b0);
    random_frames(1050);

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("** log_zero_crossing_edge_detector_top: PASSED **");
    else
      $display("** log_zero_crossing_edge_detector_top: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lzc_pkg.sv
hw/rtl/lzc_if.sv
hw/rtl/lzc_raw_store.sv
hw/rtl/lzc_gauss.sv
hw/rtl/lzc_zero_cross.sv
hw/rtl/log_zero_crossing_edge_detector_top.sv
test/testbench.sv
